@@ src/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Shared widths and reset values for the supersampled coverage block.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int RATE_W  = 5;
    localparam int COLOR_W = 8;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);

endpackage

@@ src/stc_in_if.sv @@
// ----------------------------------------------------------------------------
// stc_in_if
// Input channel: one pixel, three vertices and a color per item.
// ----------------------------------------------------------------------------
interface stc_in_if #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int SUBPIXEL_BITS    = 4
);
    import stc_pkg::*;

    localparam int VB = PIXEL_COORD_BITS + SUBPIXEL_BITS + 1;

    logic                              valid;
    logic                              ready;
    logic        [PIXEL_COORD_BITS-1:0] pixel_x;
    logic        [PIXEL_COORD_BITS-1:0] pixel_y;
    logic signed [VB-1:0]               vert_a_x;
    logic signed [VB-1:0]               vert_a_y;
    logic signed [VB-1:0]               vert_b_x;
    logic signed [VB-1:0]               vert_b_y;
    logic signed [VB-1:0]               vert_c_x;
    logic signed [VB-1:0]               vert_c_y;
    logic        [COLOR_W-1:0]          shade_red;
    logic        [COLOR_W-1:0]          shade_green;
    logic        [COLOR_W-1:0]          shade_blue;

    modport source (
        output valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
               vert_c_x, vert_c_y, shade_red, shade_green, shade_blue,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
               vert_c_x, vert_c_y, shade_red, shade_green, shade_blue,
        output ready
    );

endinterface

@@ src/stc_out_if.sv @@
// ----------------------------------------------------------------------------
// stc_out_if
// Output channel: coverage and scaled color per item.
// ----------------------------------------------------------------------------
interface stc_out_if #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int MAX_GRID_SIDE    = 4
);
    import stc_pkg::*;

    localparam int CW = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1);

    logic                        valid;
    logic                        ready;
    logic [PIXEL_COORD_BITS-1:0] out_pixel_x;
    logic [PIXEL_COORD_BITS-1:0] out_pixel_y;
    logic                        write_enable;
    logic [CW-1:0]               covered_samples;
    logic [CW-1:0]               total_samples;
    logic [COLOR_W-1:0]          out_red;
    logic [COLOR_W-1:0]          out_green;
    logic [COLOR_W-1:0]          out_blue;

    modport source (
        output valid, out_pixel_x, out_pixel_y, write_enable, covered_samples,
               total_samples, out_red, out_green, out_blue,
        input  ready
    );

    modport sink (
        input  valid, out_pixel_x, out_pixel_y, write_enable, covered_samples,
               total_samples, out_red, out_green, out_blue,
        output ready
    );

endinterface

@@ src/supersampled_triangle_coverage.sv @@
// ----------------------------------------------------------------------------
// supersampled_triangle_coverage
// Supersampled coverage of one pixel by one triangle, with color scaling.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel, three vertices (signed, SUBPIXEL_BITS fraction
//   bits) and a color per item; cov_out returns one item per input item, in
//   order: the pixel, covered and total sample counts, a write flag and each
//   color channel scaled by covered/total.
//   cfg_wr_en/cfg_wr_data load the supersample rate; the grid side is the
//   ceiling of its square root, capped at MAX_GRID_SIDE. Write it only while idle.
//   Throughput: one item per cycle while cov_out.ready stays high, set by a
//   ten-stage pipeline in which every stage is a single register level.
//   An accepted item passes through all ten register stages, the first loaded
//   at the accepting edge, before cov_out.valid rises.
//   Reset clears all valid bits and sets the supersample rate to 1.
//   When cov_out.ready is low, stages hold; empty stages upstream still fill,
//   and pix_in.ready drops only once the whole pipeline is full.
// ----------------------------------------------------------------------------
module supersampled_triangle_coverage #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int SUBPIXEL_BITS    = 4,
    parameter int MAX_GRID_SIDE    = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [stc_pkg::RATE_W-1:0]  cfg_wr_data,
    stc_in_if.sink                      pix_in,
    stc_out_if.source                   cov_out
);
    import stc_pkg::*;

    localparam int P     = PIXEL_COORD_BITS;
    localparam int VB    = P + SUBPIXEL_BITS + 1;
    localparam int DW    = VB + 1;
    localparam int DIMW  = $clog2(MAX_GRID_SIDE + 1);
    localparam int SW    = $clog2(2 * MAX_GRID_SIDE + 1);
    localparam int RW    = P + SUBPIXEL_BITS + SW + 3;
    localparam int CW    = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1);
    localparam int SIDEW = 2 * P + 3 * COLOR_W;

    logic [RATE_W-1:0] rate_reg;
    logic [DIMW-1:0]   dim;
    logic [SIDEW-1:0]  side_in;

    logic                 su_valid, su_ready;
    logic [SIDEW-1:0]     su_side;
    logic [DIMW-1:0]      su_dim;
    logic                 su_inbox;
    logic signed [RW-1:0] su_rx [3];
    logic signed [RW-1:0] su_ry [3];
    logic signed [DW-1:0] su_ex [3];
    logic signed [DW-1:0] su_ey [3];

    logic             ed_valid, ed_ready;
    logic [SIDEW-1:0] ed_side;
    logic [DIMW-1:0]  ed_dim;
    logic [CW-1:0]    ed_cov;

    logic [SIDEW-1:0] sh_side;
    logic [CW-1:0]    sh_cov;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            rate_reg <= cfg_wr_data;
        end
    end

    // grid side: smallest d with d*d >= rate, at least 1, capped
    always_comb
    begin
        dim = DIMW'(1);
        for (int i = 1; i < MAX_GRID_SIDE; i++)
        begin
            if ((i * i) < int'(rate_reg))
            begin
                dim = DIMW'(i + 1);
            end
        end
    end

    assign side_in = {pix_in.pixel_x, pix_in.pixel_y,
                      pix_in.shade_red, pix_in.shade_green, pix_in.shade_blue};

    stc_setup #(
        .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
        .SUBPIXEL_BITS    (SUBPIXEL_BITS),
        .MAX_GRID_SIDE    (MAX_GRID_SIDE)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .side_in   (side_in),
        .dim_in    (dim),
        .ax        (pix_in.vert_a_x),
        .ay        (pix_in.vert_a_y),
        .bx        (pix_in.vert_b_x),
        .by        (pix_in.vert_b_y),
        .cx        (pix_in.vert_c_x),
        .cy        (pix_in.vert_c_y),
        .out_valid (su_valid),
        .out_ready (su_ready),
        .side_out  (su_side),
        .dim_out   (su_dim),
        .inbox     (su_inbox),
        .rx        (su_rx),
        .ry        (su_ry),
        .ex        (su_ex),
        .ey        (su_ey)
    );

    stc_edge #(
        .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
        .SUBPIXEL_BITS    (SUBPIXEL_BITS),
        .MAX_GRID_SIDE    (MAX_GRID_SIDE)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .in_ready  (su_ready),
        .side_in   (su_side),
        .dim_in    (su_dim),
        .inbox_in  (su_inbox),
        .rx_in     (su_rx),
        .ry_in     (su_ry),
        .ex_in     (su_ex),
        .ey_in     (su_ey),
        .out_valid (ed_valid),
        .out_ready (ed_ready),
        .side_out  (ed_side),
        .dim_out   (ed_dim),
        .covered   (ed_cov)
    );

    stc_shade #(
        .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
        .MAX_GRID_SIDE    (MAX_GRID_SIDE)
    ) u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (ed_valid),
        .in_ready    (ed_ready),
        .side_in     (ed_side),
        .dim_in      (ed_dim),
        .covered_in  (ed_cov),
        .out_valid   (cov_out.valid),
        .out_ready   (cov_out.ready),
        .side_out    (sh_side),
        .covered_out (sh_cov),
        .total_out   (cov_out.total_samples),
        .red         (cov_out.out_red),
        .green       (cov_out.out_green),
        .blue        (cov_out.out_blue)
    );

    assign cov_out.out_pixel_x     = sh_side[SIDEW-1 -: P];
    assign cov_out.out_pixel_y     = sh_side[SIDEW-P-1 -: P];
    assign cov_out.covered_samples = sh_cov;
    assign cov_out.write_enable    = (sh_cov != '0);

    a_cov_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        cov_out.valid |-> (cov_out.covered_samples <= cov_out.total_samples))
        else $error("covered count exceeds total");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> cov_out.valid)
        else $error("input stalled with empty output stage");

    a_dark_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cov_out.valid && (cov_out.covered_samples == '0)) |->
        ((cov_out.out_red == '0) && (cov_out.out_green == '0) &&
         (cov_out.out_blue == '0)))
        else $error("color without coverage");

endmodule

@@ src/stc_setup.sv @@
// ----------------------------------------------------------------------------
// stc_setup
// Four stages: edge deltas, winding products, reorder and box test,
// sample-origin offsets per edge.
// ----------------------------------------------------------------------------
module stc_setup #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int SUBPIXEL_BITS    = 4,
    parameter int MAX_GRID_SIDE    = 4,
    localparam int VB    = PIXEL_COORD_BITS + SUBPIXEL_BITS + 1,
    localparam int DW    = VB + 1,
    localparam int DIMW  = $clog2(MAX_GRID_SIDE + 1),
    localparam int SW    = $clog2(2 * MAX_GRID_SIDE + 1),
    localparam int RW    = PIXEL_COORD_BITS + SUBPIXEL_BITS + SW + 3,
    localparam int SIDEW = 2 * PIXEL_COORD_BITS + 3 * stc_pkg::COLOR_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SIDEW-1:0]       side_in,
    input  logic [DIMW-1:0]        dim_in,
    input  logic signed [VB-1:0]   ax,
    input  logic signed [VB-1:0]   ay,
    input  logic signed [VB-1:0]   bx,
    input  logic signed [VB-1:0]   by,
    input  logic signed [VB-1:0]   cx,
    input  logic signed [VB-1:0]   cy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SIDEW-1:0]       side_out,
    output logic [DIMW-1:0]        dim_out,
    output logic                   inbox,
    output logic signed [RW-1:0]   rx [3],
    output logic signed [RW-1:0]   ry [3],
    output logic signed [DW-1:0]   ex [3],
    output logic signed [DW-1:0]   ey [3]
);
    import stc_pkg::*;

    localparam int NS = 4;
    localparam int PW = 2 * DW;
    localparam int BW = VB + 1;
    localparam int P  = PIXEL_COORD_BITS;

    function automatic logic signed [VB-1:0] min3(input logic signed [VB-1:0] a,
                                                  input logic signed [VB-1:0] b,
                                                  input logic signed [VB-1:0] c);
        logic signed [VB-1:0] r;
        r = (a < b) ? a : b;
        return (r < c) ? r : c;
    endfunction

    function automatic logic signed [VB-1:0] max3(input logic signed [VB-1:0] a,
                                                  input logic signed [VB-1:0] b,
                                                  input logic signed [VB-1:0] c);
        logic signed [VB-1:0] r;
        r = (a > b) ? a : b;
        return (r > c) ? r : c;
    endfunction

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    logic [SIDEW-1:0]     s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;
    logic [DIMW-1:0]      s1_dim_reg, s2_dim_reg, s3_dim_reg, s4_dim_reg;
    logic signed [VB-1:0] s1_x_reg [3];
    logic signed [VB-1:0] s1_y_reg [3];
    logic signed [VB-1:0] s2_x_reg [3];
    logic signed [VB-1:0] s2_y_reg [3];
    logic signed [VB-1:0] s3_x_reg [3];
    logic signed [VB-1:0] s3_y_reg [3];
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_ex_reg, s1_ey_reg;
    logic signed [PW-1:0] s2_p1_reg, s2_p2_reg;
    logic signed [VB-1:0] s2_minx_reg, s2_maxx_reg, s2_miny_reg, s2_maxy_reg;
    logic                 s3_inbox_reg, s4_inbox_reg;
    logic signed [RW-1:0] s4_rx_reg [3];
    logic signed [RW-1:0] s4_ry_reg [3];
    logic signed [DW-1:0] s4_ex_reg [3];
    logic signed [DW-1:0] s4_ey_reg [3];

    logic                 swap;
    logic signed [VB-1:0] ox [3];
    logic signed [VB-1:0] oy [3];
    logic signed [BW-1:0] xlo, xhi, ylo, yhi;
    logic                 box_hit;
    logic [SW-1:0]        s2f;
    logic signed [RW-1:0] s2s, one_r, xorg, yorg;
    logic signed [RW-1:0] rx_next [3];
    logic signed [RW-1:0] ry_next [3];
    logic signed [DW-1:0] ex_next [3];
    logic signed [DW-1:0] ey_next [3];

    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // reorder and box test
    always_comb
    begin
        swap  = s2_p1_reg > s2_p2_reg;
        ox[0] = s2_x_reg[0];
        oy[0] = s2_y_reg[0];
        ox[1] = swap ? s2_x_reg[2] : s2_x_reg[1];
        oy[1] = swap ? s2_y_reg[2] : s2_y_reg[1];
        ox[2] = swap ? s2_x_reg[1] : s2_x_reg[2];
        oy[2] = swap ? s2_y_reg[1] : s2_y_reg[2];
        xlo   = $signed(BW'(s2_side_reg[SIDEW-1 -: P]) << SUBPIXEL_BITS);
        xhi   = $signed((BW'(s2_side_reg[SIDEW-1 -: P]) + BW'(1)) << SUBPIXEL_BITS);
        ylo   = $signed(BW'(s2_side_reg[SIDEW-P-1 -: P]) << SUBPIXEL_BITS);
        yhi   = $signed((BW'(s2_side_reg[SIDEW-P-1 -: P]) + BW'(1)) << SUBPIXEL_BITS);
        box_hit = (BW'(s2_minx_reg) < xhi) && (xlo < BW'(s2_maxx_reg)) &&
                  (BW'(s2_miny_reg) < yhi) && (ylo < BW'(s2_maxy_reg));
    end

    // sample origin relative to each vertex, in units of 1/(2*dim) subpixel
    always_comb
    begin
        s2f   = SW'(s3_dim_reg) << 1;
        s2s   = $signed(RW'(s2f));
        one_r = $signed(RW'(1) << SUBPIXEL_BITS);
        xorg  = $signed(RW'(s3_side_reg[SIDEW-1 -: P]) << SUBPIXEL_BITS) * s2s + one_r;
        yorg  = $signed(RW'(s3_side_reg[SIDEW-P-1 -: P]) << SUBPIXEL_BITS) * s2s + one_r;
        for (int i = 0; i < 3; i++)
        begin
            rx_next[i] = xorg - RW'(s3_x_reg[i]) * s2s;
            ry_next[i] = yorg - RW'(s3_y_reg[i]) * s2s;
            ex_next[i] = DW'(s3_x_reg[(i == 2) ? 0 : i + 1]) - DW'(s3_x_reg[i]);
            ey_next[i] = DW'(s3_y_reg[(i == 2) ? 0 : i + 1]) - DW'(s3_y_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_side_reg <= side_in;
            s1_dim_reg  <= dim_in;
            s1_x_reg[0] <= ax;
            s1_x_reg[1] <= bx;
            s1_x_reg[2] <= cx;
            s1_y_reg[0] <= ay;
            s1_y_reg[1] <= by;
            s1_y_reg[2] <= cy;
            s1_dx_reg   <= DW'(ax) - DW'(bx);
            s1_dy_reg   <= DW'(ay) - DW'(by);
            s1_ex_reg   <= DW'(cx) - DW'(ax);
            s1_ey_reg   <= DW'(cy) - DW'(ay);
        end
        if (en[1])
        begin
            s2_side_reg <= s1_side_reg;
            s2_dim_reg  <= s1_dim_reg;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_p1_reg   <= PW'(s1_dx_reg) * PW'(s1_ey_reg);
            s2_p2_reg   <= PW'(s1_dy_reg) * PW'(s1_ex_reg);
            s2_minx_reg <= min3(s1_x_reg[0], s1_x_reg[1], s1_x_reg[2]);
            s2_maxx_reg <= max3(s1_x_reg[0], s1_x_reg[1], s1_x_reg[2]);
            s2_miny_reg <= min3(s1_y_reg[0], s1_y_reg[1], s1_y_reg[2]);
            s2_maxy_reg <= max3(s1_y_reg[0], s1_y_reg[1], s1_y_reg[2]);
        end
        if (en[2])
        begin
            s3_side_reg  <= s2_side_reg;
            s3_dim_reg   <= s2_dim_reg;
            s3_inbox_reg <= box_hit;
            s3_x_reg     <= ox;
            s3_y_reg     <= oy;
        end
        if (en[3])
        begin
            s4_side_reg  <= s3_side_reg;
            s4_dim_reg   <= s3_dim_reg;
            s4_inbox_reg <= s3_inbox_reg;
            s4_rx_reg    <= rx_next;
            s4_ry_reg    <= ry_next;
            s4_ex_reg    <= ex_next;
            s4_ey_reg    <= ey_next;
        end
    end

    assign side_out = s4_side_reg;
    assign dim_out  = s4_dim_reg;
    assign inbox    = s4_inbox_reg;
    assign rx       = s4_rx_reg;
    assign ry       = s4_ry_reg;
    assign ex       = s4_ex_reg;
    assign ey       = s4_ey_reg;

endmodule

@@ src/stc_edge.sv @@
// ----------------------------------------------------------------------------
// stc_edge
// Four stages: edge-function products at the first sample, edge function and
// per-sample step values, inside test of every grid sample, covered count.
// ----------------------------------------------------------------------------
module stc_edge #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int SUBPIXEL_BITS    = 4,
    parameter int MAX_GRID_SIDE    = 4,
    localparam int VB    = PIXEL_COORD_BITS + SUBPIXEL_BITS + 1,
    localparam int DW    = VB + 1,
    localparam int DIMW  = $clog2(MAX_GRID_SIDE + 1),
    localparam int SW    = $clog2(2 * MAX_GRID_SIDE + 1),
    localparam int RW    = PIXEL_COORD_BITS + SUBPIXEL_BITS + SW + 3,
    localparam int CW    = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1),
    localparam int SIDEW = 2 * PIXEL_COORD_BITS + 3 * stc_pkg::COLOR_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SIDEW-1:0]     side_in,
    input  logic [DIMW-1:0]      dim_in,
    input  logic                 inbox_in,
    input  logic signed [RW-1:0] rx_in [3],
    input  logic signed [RW-1:0] ry_in [3],
    input  logic signed [DW-1:0] ex_in [3],
    input  logic signed [DW-1:0] ey_in [3],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SIDEW-1:0]     side_out,
    output logic [DIMW-1:0]      dim_out,
    output logic [CW-1:0]        covered
);
    import stc_pkg::*;

    localparam int NS = 4;
    localparam int MW = RW + DW;
    localparam int EW = MW + 1;
    localparam int FW = EW + 2;
    localparam int G  = MAX_GRID_SIDE;
    localparam int NG = G * G;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    logic [SIDEW-1:0]     e1_side_reg, e2_side_reg, e3_side_reg, e4_side_reg;
    logic [DIMW-1:0]      e1_dim_reg, e2_dim_reg, e3_dim_reg, e4_dim_reg;
    logic                 e1_inbox_reg, e2_inbox_reg;
    logic signed [MW-1:0] e1_pa_reg [3];
    logic signed [MW-1:0] e1_pb_reg [3];
    logic signed [DW-1:0] e1_ex_reg [3];
    logic signed [DW-1:0] e1_ey_reg [3];
    logic signed [EW-1:0] e2_base_reg [3];
    logic signed [FW-1:0] e2_sa_reg [3];
    logic signed [FW-1:0] e2_sb_reg [3];
    logic [NG-1:0]        e3_hits_reg;
    logic [NG-1:0]        hits_next;
    logic [CW-1:0]        e4_cov_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // a sample is in when inbox is set, k, m < dim and every edge value >= 0
    always_comb
    begin
        logic signed [FW-1:0] val;
        logic                 ok;
        for (int k = 0; k < G; k++)
        begin
            for (int m = 0; m < G; m++)
            begin
                ok = e2_inbox_reg && (k < int'(e2_dim_reg)) && (m < int'(e2_dim_reg));
                for (int e = 0; e < 3; e++)
                begin
                    val = FW'(e2_base_reg[e]) + FW'(k) * e2_sa_reg[e] +
                          FW'(m) * e2_sb_reg[e];
                    ok  = ok && !val[FW-1];
                end
                hits_next[k*G+m] = ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_side_reg  <= side_in;
            e1_dim_reg   <= dim_in;
            e1_inbox_reg <= inbox_in;
            e1_ex_reg    <= ex_in;
            e1_ey_reg    <= ey_in;
            for (int i = 0; i < 3; i++)
            begin
                e1_pa_reg[i] <= MW'(rx_in[i]) * MW'(ey_in[i]);
                e1_pb_reg[i] <= MW'(ry_in[i]) * MW'(ex_in[i]);
            end
        end
        if (en[1])
        begin
            e2_side_reg  <= e1_side_reg;
            e2_dim_reg   <= e1_dim_reg;
            e2_inbox_reg <= e1_inbox_reg;
            for (int i = 0; i < 3; i++)
            begin
                e2_base_reg[i] <= EW'(e1_pb_reg[i]) - EW'(e1_pa_reg[i]);
                e2_sa_reg[i]   <= -(FW'(e1_ey_reg[i]) <<< (SUBPIXEL_BITS + 1));
                e2_sb_reg[i]   <= FW'(e1_ex_reg[i]) <<< (SUBPIXEL_BITS + 1);
            end
        end
        if (en[2])
        begin
            e3_side_reg <= e2_side_reg;
            e3_dim_reg  <= e2_dim_reg;
            e3_hits_reg <= hits_next;
        end
        if (en[3])
        begin
            e4_side_reg <= e3_side_reg;
            e4_dim_reg  <= e3_dim_reg;
            e4_cov_reg  <= CW'($countones(e3_hits_reg));
        end
    end

    assign side_out = e4_side_reg;
    assign dim_out  = e4_dim_reg;
    assign covered  = e4_cov_reg;

endmodule

@@ src/stc_shade.sv @@
// ----------------------------------------------------------------------------
// stc_shade
// Two stages: color times count with reciprocal lookup, then the scaled
// quotient. The second stage is the output register.
// ----------------------------------------------------------------------------
module stc_shade #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int MAX_GRID_SIDE    = 4,
    localparam int DIMW  = $clog2(MAX_GRID_SIDE + 1),
    localparam int CW    = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1),
    localparam int SIDEW = 2 * PIXEL_COORD_BITS + 3 * stc_pkg::COLOR_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SIDEW-1:0]            side_in,
    input  logic [DIMW-1:0]             dim_in,
    input  logic [CW-1:0]               covered_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SIDEW-1:0]            side_out,
    output logic [CW-1:0]               covered_out,
    output logic [CW-1:0]               total_out,
    output logic [stc_pkg::COLOR_W-1:0] red,
    output logic [stc_pkg::COLOR_W-1:0] green,
    output logic [stc_pkg::COLOR_W-1:0] blue
);
    import stc_pkg::*;

    localparam int NS        = 2;
    localparam int G         = MAX_GRID_SIDE;
    localparam int VW        = COLOR_W + CW;
    localparam int DIV_SHIFT = VW + CW;
    localparam int RCW       = DIV_SHIFT + 1;
    localparam int QW        = VW + RCW;
    localparam int IW        = (G > 1) ? $clog2(G) : 1;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    logic [RCW-1:0]     recip_tbl [G];
    logic [DIMW-1:0]    dim_m1;
    logic [SIDEW-1:0]   h1_side_reg, h2_side_reg;
    logic [CW-1:0]      h1_cov_reg, h2_cov_reg;
    logic [CW-1:0]      h1_total_reg, h2_total_reg;
    logic [RCW-1:0]     h1_recip_reg;
    logic [VW-1:0]      h1_v_reg [3];
    logic [COLOR_W-1:0] h2_q_reg [3];
    logic [QW-1:0]      prod [3];

    genvar gd;
    generate
        for (gd = 0; gd < G; gd++)
        begin : g_recip
            localparam longint T = (gd + 1) * (gd + 1);
            localparam longint R = ((longint'(1) << DIV_SHIFT) + T - 1) / T;
            assign recip_tbl[gd] = RCW'(R);
        end
    endgenerate

    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign dim_m1    = dim_in - DIMW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = QW'(h1_v_reg[i]) * QW'(h1_recip_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h1_side_reg  <= side_in;
            h1_cov_reg   <= covered_in;
            h1_total_reg <= CW'(dim_in) * CW'(dim_in);
            h1_recip_reg <= recip_tbl[dim_m1[IW-1:0]];
            for (int i = 0; i < 3; i++)
            begin
                h1_v_reg[i] <= VW'(side_in[(2 - i) * COLOR_W +: COLOR_W]) * VW'(covered_in);
            end
        end
        if (en[1])
        begin
            h2_side_reg  <= h1_side_reg;
            h2_cov_reg   <= h1_cov_reg;
            h2_total_reg <= h1_total_reg;
            for (int i = 0; i < 3; i++)
            begin
                h2_q_reg[i] <= prod[i][DIV_SHIFT +: COLOR_W];
            end
        end
    end

    assign side_out    = h2_side_reg;
    assign covered_out = h2_cov_reg;
    assign total_out   = h2_total_reg;
    assign red         = h2_q_reg[0];
    assign green       = h2_q_reg[1];
    assign blue        = h2_q_reg[2];

endmodule
